>>> hw/rtl/dlsq_pkg.sv
// ============================================================================
// dlsq_pkg
// Shared widths, defaults and codes for the delta-list sleep queue.
// ============================================================================
package dlsq_pkg;

    localparam int ID_W          = 8;
    localparam int SLEEP_W       = 32;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int MAX_WAKE      = 16;
    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_TICK   = 2'd1;
    localparam t_kind KIND_REMOVE = 2'd2;
    localparam t_kind KIND_CLEAR  = 2'd3;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_MISS = 2'd2;

endpackage

>>> hw/rtl/delta_list_sleep_queue.sv
// ============================================================================
// delta_list_sleep_queue
// Timer queue of sleeping thread handles kept in wake order as a delta list,
// one entry per word of a RAM, walked by a small sequencer.
// ============================================================================
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_kind, i_thread_id, i_sleep_ticks
//  out      output     o_out_valid / i_out_ready o_woken_id, o_woke, o_status, o_last
//
//  one beat at a time; every RAM step is a read state followed by a use
//  state. An insert walks the list and shifts the tail, a remove compacts
//  the list, a tick releases head entries (head pops shift the RAM); a clear,
//  a full-store insert or an empty tick or remove goes straight to the result.
//  i_rst_n is synchronous; it empties the queue, RAM contents are left as is.
//  a stalled output holds the sequencer only where it has a beat to load.
//
module delta_list_sleep_queue
    import dlsq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [ID_W-1:0]    i_thread_id,
    input  logic [SLEEP_W-1:0] i_sleep_ticks,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [ID_W-1:0]    o_woken_id,
    output logic               o_woke,
    output logic [STATUS_W-1:0] o_status,
    output logic               o_last
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int WW  = ID_W + TIME_BITS;
    localparam int NWW = $clog2(MAX_WAKE + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_CMP = 4'd2;
    localparam logic [3:0] S_SH_RD   = 4'd3;
    localparam logic [3:0] S_SH_WR   = 4'd4;
    localparam logic [3:0] S_INS_PUT = 4'd5;
    localparam logic [3:0] S_TK_RD   = 4'd6;
    localparam logic [3:0] S_TK_CHK  = 4'd7;
    localparam logic [3:0] S_TK_EMIT = 4'd8;
    localparam logic [3:0] S_TK_TAKE = 4'd9;
    localparam logic [3:0] S_POP_RD  = 4'd10;
    localparam logic [3:0] S_POP_WR  = 4'd11;
    localparam logic [3:0] S_RM_RD   = 4'd12;
    localparam logic [3:0] S_RM_CHK  = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    function automatic logic [TIME_BITS-1:0] sat_add(
        input logic [TIME_BITS-1:0] a,
        input logic [TIME_BITS-1:0] b
    );
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

    logic [3:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_pos, n_pos;
    logic [CW-1:0]        r_wr, n_wr;
    logic [TIME_BITS-1:0] r_prefix, n_prefix;
    logic [TIME_BITS-1:0] r_next, n_next;
    logic [TIME_BITS-1:0] r_t, n_t;
    logic [ID_W-1:0]      r_id, n_id;
    logic [ID_W-1:0]      r_cand_id, n_cand_id;
    logic                 r_found, n_found;
    logic                 r_first, n_first;
    logic                 r_pend, n_pend;
    logic [NWW-1:0]       r_nwake, n_nwake;
    logic [ID_W-1:0]      r_res_id, n_res_id;
    logic                 r_res_woke, n_res_woke;
    t_status              r_res_status, n_res_status;

    logic                 r_out_valid, n_out_valid;
    logic [ID_W-1:0]      r_out_id, n_out_id;
    logic                 r_out_woke, n_out_woke;
    t_status              r_out_status, n_out_status;
    logic                 r_out_last, n_out_last;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WW-1:0]        w_wdata;
    logic [AW-1:0]        w_raddr;
    logic [WW-1:0]        w_rdata;
    logic [ID_W-1:0]      w_rd_id;
    logic [TIME_BITS-1:0] w_rd_delta;
    logic [TIME_BITS-1:0] w_sum;
    logic [TIME_BITS-1:0] w_t_in;
    logic [TIME_BITS-1:0] w_t;
    logic [TIME_BITS-1:0] w_head;
    logic [CW-1:0]        w_pos_inc;
    logic [CW-1:0]        w_shift_src;
    logic                 w_accept;
    logic                 w_out_free;

    if (TIME_BITS >= SLEEP_W) begin : g_t_wide
        assign w_t_in = TIME_BITS'(i_sleep_ticks);
    end else begin : g_t_narrow
        assign w_t_in = (|(i_sleep_ticks >> TIME_BITS)) ? {TIME_BITS{1'b1}}
                                                         : i_sleep_ticks[TIME_BITS-1:0];
    end

    assign w_t         = (w_t_in == '0) ? TIME_BITS'(1) : w_t_in;
    assign w_rd_id     = w_rdata[WW-1 -: ID_W];
    assign w_rd_delta  = w_rdata[TIME_BITS-1:0];
    assign w_sum       = sat_add(r_prefix, w_rd_delta);
    assign w_head      = (r_first && (w_rd_delta != '0)) ? (w_rd_delta - TIME_BITS'(1))
                                                        : w_rd_delta;
    assign w_pos_inc   = r_pos + CW'(1);
    assign w_shift_src = r_wr - CW'(1);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    dlsq_ram #(
        .WIDTH(WW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_wr         = r_wr;
        n_prefix     = r_prefix;
        n_next       = r_next;
        n_t          = r_t;
        n_id         = r_id;
        n_cand_id    = r_cand_id;
        n_found      = r_found;
        n_first      = r_first;
        n_pend       = r_pend;
        n_nwake      = r_nwake;
        n_res_id     = r_res_id;
        n_res_woke   = r_res_woke;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_id     = r_out_id;
        n_out_woke   = r_out_woke;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        w_we         = 1'b0;
        w_waddr      = r_pos[AW-1:0];
        w_wdata      = w_rdata;
        w_raddr      = r_pos[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_id         = i_thread_id;
                    n_t          = w_t;
                    n_pos        = '0;
                    n_wr         = '0;
                    n_prefix     = '0;
                    n_found      = 1'b0;
                    n_first      = 1'b1;
                    n_pend       = 1'b0;
                    n_nwake      = '0;
                    n_res_id     = '0;
                    n_res_woke   = 1'b0;
                    n_res_status = ST_OK;
                    case (i_kind)
                        KIND_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_res_status = ST_FULL;
                                n_state      = S_DONE;
                            end else if (r_count == '0) begin
                                n_state = S_INS_PUT;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        KIND_TICK: begin
                            n_state = (r_count == '0) ? S_DONE : S_TK_RD;
                        end
                        KIND_REMOVE: begin
                            if (r_count == '0) begin
                                n_res_status = ST_MISS;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_RM_RD;
                            end
                        end
                        KIND_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_RD: begin
                n_state = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (r_t < w_sum) begin
                    n_next  = w_sum;
                    n_wr    = r_count;
                    n_state = S_SH_RD;
                end else begin
                    n_prefix = w_sum;
                    n_pos    = w_pos_inc;
                    n_state  = (w_pos_inc == r_count) ? S_INS_PUT : S_INS_RD;
                end
            end
            S_SH_RD: begin
                w_raddr = w_shift_src[AW-1:0];
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                w_we    = 1'b1;
                w_waddr = r_wr[AW-1:0];
                if (w_shift_src == r_pos) begin
                    w_wdata = {w_rd_id, r_next - r_t};
                    n_state = S_INS_PUT;
                end else begin
                    n_state = S_SH_RD;
                end
                n_wr = w_shift_src;
            end
            S_INS_PUT: begin
                w_we    = 1'b1;
                w_wdata = {r_id, r_t - r_prefix};
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_TK_RD: begin
                w_raddr = '0;
                n_state = S_TK_CHK;
            end
            S_TK_CHK: begin
                w_waddr = '0;
                w_wdata = {w_rd_id, w_head};
                w_we    = r_first && (w_rd_delta != '0);
                n_first = 1'b0;
                if (w_head == '0) begin
                    n_cand_id = w_rd_id;
                    n_state   = r_pend ? S_TK_EMIT : S_TK_TAKE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_TK_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_id     = r_res_id;
                    n_out_woke   = 1'b1;
                    n_out_status = ST_OK;
                    n_out_last   = 1'b0;
                    n_state      = S_TK_TAKE;
                end
            end
            S_TK_TAKE: begin
                n_res_id   = r_cand_id;
                n_res_woke = 1'b1;
                n_pend     = 1'b1;
                n_nwake    = r_nwake + NWW'(1);
                n_count    = r_count - CW'(1);
                n_pos      = '0;
                n_state    = (r_count == CW'(1)) ? S_DONE : S_POP_RD;
            end
            S_POP_RD: begin
                w_raddr = w_pos_inc[AW-1:0];
                n_state = S_POP_WR;
            end
            S_POP_WR: begin
                w_we  = 1'b1;
                n_pos = w_pos_inc;
                if (w_pos_inc == r_count) begin
                    n_state = (r_nwake == NWW'(MAX_WAKE)) ? S_DONE : S_TK_RD;
                end else begin
                    n_state = S_POP_RD;
                end
            end
            S_RM_RD: begin
                n_state = S_RM_CHK;
            end
            S_RM_CHK: begin
                n_pos = w_pos_inc;
                if (w_rd_id == r_id) begin
                    n_prefix = w_sum;
                    n_found  = 1'b1;
                end else begin
                    w_we     = 1'b1;
                    w_waddr  = r_wr[AW-1:0];
                    w_wdata  = {w_rd_id, w_sum};
                    n_prefix = '0;
                    n_wr     = r_wr + CW'(1);
                end
                if (w_pos_inc == r_count) begin
                    n_count      = n_wr;
                    n_res_status = n_found ? ST_OK : ST_MISS;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_RM_RD;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_id     = r_res_id;
                    n_out_woke   = r_res_woke;
                    n_out_status = r_res_status;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_first     <= 1'b0;
            r_found     <= 1'b0;
            r_nwake     <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_first     <= n_first;
            r_found     <= n_found;
            r_nwake     <= n_nwake;
        end
        r_pos        <= n_pos;
        r_wr         <= n_wr;
        r_prefix     <= n_prefix;
        r_next       <= n_next;
        r_t          <= n_t;
        r_id         <= n_id;
        r_cand_id    <= n_cand_id;
        r_res_id     <= n_res_id;
        r_res_woke   <= n_res_woke;
        r_res_status <= n_res_status;
        r_out_id     <= n_out_id;
        r_out_woke   <= n_out_woke;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_woken_id  = r_out_id;
    assign o_woke      = r_out_woke;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_waddr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ({1'b0, w_waddr} < (AW + 1)'(DEPTH)))
        else $error("ram write beyond depth");

    a_wake_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nwake <= NWW'(MAX_WAKE))
        else $error("too many releases in one tick");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_kind == KIND_CLEAR)) |=> (r_count == '0))
        else $error("clear left entries");

    a_remove_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RM_CHK) |-> (r_wr <= r_pos))
        else $error("remove write index passed read index");

endmodule

>>> hw/rtl/dlsq_ram.sv
// ============================================================================
// dlsq_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module dlsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> verif/tb_delta_list_sleep_queue.sv
// ============================================================================
// tb_delta_list_sleep_queue
// Self-checking bench for the delta-list sleep queue. A scoreboard keeps its
// own copy of the delta list, predicts the result beats of every accepted
// input beat and compares each output beat field by field. A directed
// opening covers edge sleeps, the full store, misses and a full release.
// Random phases with sender gaps, receiver stalls and a long output hold-off
// follow.
// ============================================================================

typedef struct packed {
    logic [dlsq_pkg::ID_W-1:0]     woken_id;
    logic                          woke;
    logic [dlsq_pkg::STATUS_W-1:0] status;
    logic                          last;
} t_wake_beat;

class sleep_queue_scoreboard;
    localparam int QDEPTH = dlsq_pkg::DEPTH_DEF;

    logic [dlsq_pkg::ID_W-1:0] ids[QDEPTH];
    logic [31:0]               deltas[QDEPTH];
    int                        count;
    t_wake_beat                wake_q[$];
    int                        errors;

    function new();
        count  = 0;
        errors = 0;
    endfunction

    function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void push_beat(logic [7:0] id, logic woke, logic [1:0] status, logic last);
        t_wake_beat b;
        b.woken_id = id;
        b.woke     = woke;
        b.status   = status;
        b.last     = last;
        wake_q.push_back(b);
    endfunction

    function int pending();
        return wake_q.size();
    endfunction

    function void insert_entry(logic [7:0] id, logic [31:0] ticks);
        logic [31:0] t;
        logic [31:0] prefix;
        logic [31:0] next;
        int          pos;
        int          i;
        bit          done;
        if (count >= QDEPTH) begin
            push_beat(8'd0, 1'b0, dlsq_pkg::ST_FULL, 1'b1);
            return;
        end
        t = (ticks == 0) ? 32'd1 : ticks;
        pos = 0;
        prefix = 0;
        done = 0;
        while (!done && pos < count) begin
            next = sat_sum(prefix, deltas[pos]);
            if (t < next) begin
                done = 1;
            end else begin
                prefix = next;
                pos++;
            end
        end
        if (pos < count) deltas[pos] = sat_sum(prefix, deltas[pos]) - t;
        for (i = count; i > pos; i--) begin
            ids[i]    = ids[i-1];
            deltas[i] = deltas[i-1];
        end
        ids[pos]    = id;
        deltas[pos] = t - prefix;
        count++;
        push_beat(8'd0, 1'b0, dlsq_pkg::ST_OK, 1'b1);
    endfunction

    function void tick_queue();
        int         n;
        int         i;
        t_wake_beat b;
        n = 0;
        if (count > 0 && deltas[0] > 0) deltas[0] = deltas[0] - 1;
        while (count > 0 && deltas[0] == 0 && n < dlsq_pkg::MAX_WAKE) begin
            push_beat(ids[0], 1'b1, dlsq_pkg::ST_OK, 1'b0);
            n++;
            for (i = 0; i + 1 < count; i++) begin
                ids[i]    = ids[i+1];
                deltas[i] = deltas[i+1];
            end
            count--;
        end
        if (n == 0) begin
            push_beat(8'd0, 1'b0, dlsq_pkg::ST_OK, 1'b1);
        end else begin
            b = wake_q.pop_back();
            b.last = 1'b1;
            wake_q.push_back(b);
        end
    endfunction

    function void remove_entries(logic [7:0] id);
        int          rd;
        int          wr;
        logic [31:0] carry;
        logic [31:0] d;
        bit          found;
        wr = 0;
        carry = 0;
        found = 0;
        for (rd = 0; rd < count; rd++) begin
            d = sat_sum(carry, deltas[rd]);
            if (ids[rd] == id) begin
                carry = d;
                found = 1;
            end else begin
                ids[wr]    = ids[rd];
                deltas[wr] = d;
                carry = 0;
                wr++;
            end
        end
        count = wr;
        push_beat(8'd0, 1'b0, found ? dlsq_pkg::ST_OK : dlsq_pkg::ST_MISS, 1'b1);
    endfunction

    function void note_input(dlsq_pkg::t_kind kind, logic [7:0] id, logic [31:0] ticks);
        case (kind)
            dlsq_pkg::KIND_INSERT: insert_entry(id, ticks);
            dlsq_pkg::KIND_TICK:   tick_queue();
            dlsq_pkg::KIND_REMOVE: remove_entries(id);
            default: begin
                count = 0;
                push_beat(8'd0, 1'b0, dlsq_pkg::ST_OK, 1'b1);
            end
        endcase
    endfunction

    task report(string msg);
        errors++;
        $display("ERROR: %s", msg);
    endtask

    task check_result(t_wake_beat got);
        t_wake_beat want;
        if (wake_q.size() == 0) begin
            report($sformatf("unexpected beat id=%0d woke=%0d status=%0d last=%0d",
                             got.woken_id, got.woke, got.status, got.last));
            return;
        end
        want = wake_q.pop_front();
        if (got.woken_id != want.woken_id)
            report($sformatf("woken_id expected %0d got %0d", want.woken_id, got.woken_id));
        if (got.woke != want.woke)
            report($sformatf("woke expected %0d got %0d", want.woke, got.woke));
        if (got.status != want.status)
            report($sformatf("status expected %0d got %0d", want.status, got.status));
        if (got.last != want.last)
            report($sformatf("last expected %0d got %0d", want.last, got.last));
    endtask
endclass

module tb_delta_list_sleep_queue;
    import dlsq_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic [KIND_W-1:0]   i_kind        = '0;
    logic [ID_W-1:0]     i_thread_id   = '0;
    logic [SLEEP_W-1:0]  i_sleep_ticks = '0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic [ID_W-1:0]     o_woken_id;
    logic                o_woke;
    logic [STATUS_W-1:0] o_status;
    logic                o_last;

    sleep_queue_scoreboard sb;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    logic recv_hold     = 1'b0;
    int  cycle_count    = 0;

    delta_list_sleep_queue i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_thread_id   (i_thread_id),
        .i_sleep_ticks (i_sleep_ticks),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_woken_id    (o_woken_id),
        .o_woke        (o_woke),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("delta_list_sleep_queue: mismatch");
            $finish;
        end
    end

    // receiver side: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || recv_hold) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_wake_beat got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.woken_id = o_woken_id;
            got.woke     = o_woke;
            got.status   = o_status;
            got.last     = o_last;
            sb.check_result(got);
        end
    end

    task automatic send_beat(t_kind kind, logic [ID_W-1:0] id, logic [SLEEP_W-1:0] ticks);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_thread_id   <= id;
        i_sleep_ticks <= ticks;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(kind, id, ticks);
    endtask

    task automatic send_random();
        int               r;
        int               s;
        t_kind            kind;
        logic [ID_W-1:0]  id;
        logic [SLEEP_W-1:0] ticks;
        r  = $urandom_range(99);
        s  = $urandom_range(19);
        id = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
        if (s < 12)      ticks = $urandom_range(6);
        else if (s < 17) ticks = $urandom_range(60);
        else if (s < 18) ticks = '0;
        else             ticks = $urandom();
        if (r < 42)      kind = KIND_INSERT;
        else if (r < 77) kind = KIND_TICK;
        else if (r < 93) kind = KIND_REMOVE;
        else if (r < 96) kind = KIND_CLEAR;
        else begin
            // noise beat
            kind  = t_kind'($urandom_range(3));
            id    = 8'($urandom_range(255));
            ticks = $urandom();
        end
        send_beat(kind, id, ticks);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic hold_receiver(int cycles);
        recv_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        recv_hold <= 1'b0;
    endtask

    task automatic run_phase(int send_pct, int recv_pct, int n);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n) send_random();
        drain();
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening
        send_beat(KIND_TICK, 8'd0, 32'd0);
        send_beat(KIND_INSERT, 8'd0, 32'd0);
        send_beat(KIND_INSERT, 8'd255, 32'hFFFF_FFFF);
        send_beat(KIND_INSERT, 8'd9, 32'hFFFF_FFFF);
        send_beat(KIND_TICK, 8'd0, 32'd0);
        send_beat(KIND_REMOVE, 8'd255, 32'd0);
        send_beat(KIND_REMOVE, 8'd255, 32'd0);
        send_beat(KIND_CLEAR, 8'd0, 32'd0);
        send_beat(KIND_REMOVE, 8'd3, 32'd0);
        for (int i = 0; i < DEPTH_DEF; i++) begin
            send_beat(KIND_INSERT, 8'(i * 17), 32'(i % 2));
        end
        send_beat(KIND_INSERT, 8'd77, 32'd5);
        send_beat(KIND_TICK, 8'd0, 32'd0);
        drain();

        // long output hold-off while the sender keeps offering
        fork
            hold_receiver(400);
        join_none
        run_phase(0, 0, 95);
        run_phase(62, 0, 95);
        run_phase(0, 62, 95);
        run_phase(16, 16, 95);

        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("delta_list_sleep_queue: match");
        end else begin
            $display("delta_list_sleep_queue: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/dlsq_pkg.sv
hw/rtl/dlsq_ram.sv
hw/rtl/delta_list_sleep_queue.sv
verif/tb_delta_list_sleep_queue.sv
